FILE: hdl/mna_pkg.sv
package mna_pkg;

  typedef enum logic [1:0] {
    NK_MAX  = 2'd0,
    NK_SUM  = 2'd1,
    NK_ROOT = 2'd2,
    NK_SQ   = 2'd3
  } norm_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_FOLD,
    S_LOAD,
    S_ROOT,
    S_EMIT
  } mna_state_t;

  // register indexes on the config port
  localparam logic REG_NORM_KIND = 1'b0;
  localparam logic REG_ELEM_TYPE = 1'b1;

  // element type fields
  localparam int unsigned ET_SIGNED_BIT = 0;
  localparam logic [1:0] ET_SIZE_8  = 2'd0;
  localparam logic [1:0] ET_SIZE_16 = 2'd1;

  // one root bit per step
  localparam int unsigned ROOT_STEPS = 64;
  localparam int unsigned ROOT_CNT_W = $clog2(ROOT_STEPS);

  typedef struct packed {
    logic cap;
    logic square;
    logic fold;
    logic root_init;
    logic root_step;
    logic emit;
  } mna_cmd_t;

  typedef struct packed {
    logic out_busy;
  } mna_stat_t;

endpackage

FILE: hdl/mna_ctrl.sv
module mna_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tlast,
  output logic                  in_tready,
  input  mna_pkg::norm_kind_t   norm_kind,
  input  mna_pkg::mna_stat_t    stat,
  output mna_pkg::mna_cmd_t     cmd
);

  mna_pkg::mna_state_t state_r, state_nxt;
  logic last_r, last_nxt;
  logic [mna_pkg::ROOT_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mna_pkg::S_IDLE;
      last_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      mna_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap  = 1'b1;
          last_nxt = in_tlast;
          if (norm_kind == mna_pkg::NK_ROOT || norm_kind == mna_pkg::NK_SQ) begin
            state_nxt = mna_pkg::S_SQUARE;
          end else begin
            state_nxt = mna_pkg::S_FOLD;
          end
        end
      end
      mna_pkg::S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = mna_pkg::S_FOLD;
      end
      mna_pkg::S_FOLD: begin
        cmd.fold = 1'b1;
        if (!last_r) begin
          state_nxt = mna_pkg::S_IDLE;
        end else if (norm_kind == mna_pkg::NK_ROOT) begin
          state_nxt = mna_pkg::S_LOAD;
        end else begin
          state_nxt = mna_pkg::S_EMIT;
        end
      end
      // radicand is loaded once the last element has been folded in
      mna_pkg::S_LOAD: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = mna_pkg::S_ROOT;
      end
      mna_pkg::S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == mna_pkg::ROOT_CNT_W'(mna_pkg::ROOT_STEPS - 1)) begin
          state_nxt = mna_pkg::S_EMIT;
        end
      end
      mna_pkg::S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = mna_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mna_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/mna_dp.sv
module mna_dp #(
  parameter int unsigned ROOT_FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mna_pkg::mna_cmd_t    cmd,
  output mna_pkg::mna_stat_t   stat,
  input  mna_pkg::norm_kind_t  norm_kind,
  input  logic [2:0]           elem_type,
  input  logic [32:0]          element_value,
  output logic [63:0]          out_tdata,
  output logic                 out_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready
);

  localparam int unsigned RootShift = 2 * ROOT_FRACTION_BITS;

  logic [31:0]  mag_r;
  logic [63:0]  sq_r;
  logic [63:0]  acc_r;
  logic         clip_r;
  logic [127:0] rad_r;
  logic [66:0]  rem_r;
  logic [63:0]  root_r;
  logic [63:0]  out_data_r;
  logic         out_user_r;
  logic         out_valid_r;

  // element magnitude
  logic        elem_signed;
  logic [32:0] ext_v;
  logic [32:0] neg_v;
  logic [31:0] mag_nxt;

  always_comb begin
    elem_signed = elem_type[mna_pkg::ET_SIGNED_BIT];
    case (elem_type[2:1])
      mna_pkg::ET_SIZE_8:
        ext_v = {{25{elem_signed & element_value[7]}}, element_value[7:0]};
      mna_pkg::ET_SIZE_16:
        ext_v = {{17{elem_signed & element_value[15]}}, element_value[15:0]};
      default:
        ext_v = {elem_signed & element_value[31], element_value[31:0]};
    endcase
    neg_v   = 33'd0 - ext_v;
    mag_nxt = ext_v[32] ? neg_v[31:0] : ext_v[31:0];
  end

  // saturating fold
  logic [63:0] addend;
  logic [64:0] sum;

  always_comb begin
    addend = (norm_kind == mna_pkg::NK_SUM) ? {32'd0, mag_r} : sq_r;
    sum    = {1'b0, acc_r} + {1'b0, addend};
  end

  // one restoring root step
  logic [66:0] rem_sh;
  logic [66:0] trial;
  logic [66:0] diff;
  logic        take;

  always_comb begin
    rem_sh = {rem_r[64:0], rad_r[127:126]};
    trial  = {1'b0, root_r, 2'b01};
    diff   = rem_sh - trial;
    take   = rem_sh >= trial;
  end

  assign stat.out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mag_r <= mag_nxt;
    end
    if (cmd.square) begin
      sq_r <= mag_r * mag_r;
    end
    if (cmd.root_init) begin
      rad_r  <= {64'd0, acc_r} << RootShift;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[125:0], 2'b00};
      rem_r  <= take ? diff : rem_sh;
      root_r <= {root_r[62:0], take};
    end
    if (cmd.emit) begin
      out_data_r <= (norm_kind == mna_pkg::NK_ROOT) ? root_r : acc_r;
      out_user_r <= clip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        acc_r  <= '0;
        clip_r <= 1'b0;
      end else if (cmd.fold) begin
        if (norm_kind == mna_pkg::NK_MAX) begin
          if ({32'd0, mag_r} > acc_r) begin
            acc_r <= {32'd0, mag_r};
          end
        end else if (sum[64]) begin
          acc_r  <= '1;
          clip_r <= 1'b1;
        end else begin
          acc_r <= sum[63:0];
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

endmodule

FILE: hdl/matrix_norm_accumulator.sv
// Matrix norm accumulator. Streams matrix elements, reads each one as u8/s8/u16/s16/u32/s32
// per elem_type, and folds its magnitude into one 64-bit accumulator as a running maximum,
// a sum of magnitudes, or a sum of squares, per norm_kind. Sums saturate at 2^64-1 and set
// the saturated flag of the result. The beat with tlast set closes the matrix: one result
// beat comes out and the accumulator clears. For the root kind the result is the floor of
// the square root in unsigned fixed point with ROOT_FRACTION_BITS fraction bits. Each input
// beat is captured and then folded in; the square kinds square it in between, through the
// registered 32x32 multiplier. A closing beat then loads the output register, and for the
// root kind the radicand is loaded first, then one root bit per cycle comes from the
// restoring square-root unit. The output register lets the block take new beats while a
// result waits; a second result waits in the controller until the first has been taken.
// Configuration is taken at any cycle and must only change while the block is idle.
module matrix_norm_accumulator #(
  parameter int unsigned ROOT_FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // [32:0] element_value, [39:33] zero
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [63:0] norm_value
  output logic [63:0] out_tdata,
  // [0] saturated
  output logic [0:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  mna_pkg::norm_kind_t norm_kind_r;
  logic [2:0]          elem_type_r;
  mna_pkg::mna_cmd_t   cmd;
  mna_pkg::mna_stat_t  stat;
  logic                sat_flag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_kind_r <= mna_pkg::NK_MAX;
      elem_type_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mna_pkg::REG_NORM_KIND: norm_kind_r <= mna_pkg::norm_kind_t'(cfg_data[1:0]);
        mna_pkg::REG_ELEM_TYPE: elem_type_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mna_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .norm_kind (norm_kind_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  mna_dp #(
    .ROOT_FRACTION_BITS (ROOT_FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .norm_kind     (norm_kind_r),
    .elem_type     (elem_type_r),
    .element_value (in_tdata[32:0]),
    .out_tdata     (out_tdata),
    .out_tuser     (sat_flag),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready)
  );

  assign out_tuser[0] = sat_flag;

`ifndef SYNTHESIS
  // a result never appears in the cycle right after a beat is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result raised right after input beat");

  // one element in flight: busy in the cycle after a beat is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while previous element in flight");

  // no result pending out of reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule

FILE: test/norm_result_checker.sv
`timescale 1ns / 100ps
module norm_result_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [63:0] norm;
    logic        clip;
  } norm_result_t;

  norm_result_t         expected_norms[$];
  mna_pkg::norm_kind_t  kind_now = mna_pkg::NK_MAX;
  logic [2:0]           type_now = '0;
  logic [63:0]          running_acc = '0;
  logic                 clip_flag = 1'b0;

  // magnitude of the element read at the configured width and signedness
  function automatic logic [31:0] abs_of_element(input logic [32:0] v, input logic [2:0] et);
    logic [31:0] w;
    case (et[2:1])
      mna_pkg::ET_SIZE_8: begin
        w = {24'd0, v[7:0]};
        if (et[mna_pkg::ET_SIGNED_BIT] && v[7]) w = 32'd256 - {24'd0, v[7:0]};
      end
      mna_pkg::ET_SIZE_16: begin
        w = {16'd0, v[15:0]};
        if (et[mna_pkg::ET_SIGNED_BIT] && v[15]) w = 32'd65536 - {16'd0, v[15:0]};
      end
      default: begin
        w = v[31:0];
        if (et[mna_pkg::ET_SIGNED_BIT] && v[31]) begin
          w = 32'(33'h1_0000_0000 - {1'b0, v[31:0]});
        end
      end
    endcase
    return w;
  endfunction

  // greedy bit-by-bit search for floor(sqrt(a * 2^(2*FRAC_BITS)))
  function automatic logic [63:0] fixed_sqrt(input logic [63:0] a);
    logic [127:0] rad;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  cand;
    rad = {64'd0, a} << (2 * FRAC_BITS);
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= rad) r = cand;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [31:0]  mag;
    logic [63:0]  addend;
    logic [64:0]  sum;
    norm_result_t exp_r;
    if (!rst_n) begin
      kind_now = mna_pkg::NK_MAX;
      type_now = '0;
      running_acc = '0;
      clip_flag = 1'b0;
      mismatches = 0;
      expected_norms.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mna_pkg::REG_NORM_KIND) begin
          kind_now = mna_pkg::norm_kind_t'(cfg_data[1:0]);
        end else begin
          type_now = cfg_data;
        end
      end

      if (out_tvalid && out_tready) begin
        if (expected_norms.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, actual norm %h saturated %b",
                   $time, out_tdata, out_tuser[0]);
        end else begin
          exp_r = expected_norms.pop_front();
          if (out_tdata !== exp_r.norm) begin
            mismatches++;
            $display("%0t: norm_value expected %h actual %h", $time, exp_r.norm, out_tdata);
          end
          if (out_tuser[0] !== exp_r.clip) begin
            mismatches++;
            $display("%0t: saturated expected %b actual %b", $time, exp_r.clip, out_tuser[0]);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        mag = abs_of_element(in_tdata[32:0], type_now);
        if (kind_now == mna_pkg::NK_MAX) begin
          if ({32'd0, mag} > running_acc) running_acc = {32'd0, mag};
        end else begin
          addend = (kind_now == mna_pkg::NK_SUM) ? {32'd0, mag} :
                   {32'd0, mag} * {32'd0, mag};
          sum = {1'b0, running_acc} + {1'b0, addend};
          if (sum[64]) begin
            running_acc = '1;
            clip_flag = 1'b1;
          end else begin
            running_acc = sum[63:0];
          end
        end
        if (in_tlast) begin
          exp_r.norm = (kind_now == mna_pkg::NK_ROOT) ? fixed_sqrt(running_acc) : running_acc;
          exp_r.clip = clip_flag;
          expected_norms.push_back(exp_r);
          running_acc = '0;
          clip_flag = 1'b0;
        end
      end
    end
    outstanding <= expected_norms.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned RANDOM_ITEMS  = 1850;
  localparam int unsigned QUIET_TAIL    = 250;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  localparam logic [2:0] ET_U8      = 3'd0;
  localparam logic [2:0] ET_S8      = 3'd1;
  localparam logic [2:0] ET_U16     = 3'd2;
  localparam logic [2:0] ET_S16     = 3'd3;
  localparam logic [2:0] ET_U32     = 3'd4;
  localparam logic [2:0] ET_S32     = 3'd5;
  localparam logic [2:0] ET_U32_ALT = 3'd6;
  localparam logic [2:0] ET_S32_ALT = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [39:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [2:0]  cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  logic [2:0]  cur_type = ET_U8;

  always #6 clk = ~clk;

  matrix_norm_accumulator #(
    .ROOT_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  norm_result_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stall bursts, plus the long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [32:0] pick_value(input logic [2:0] et);
    logic [32:0] r;
    logic [32:0] mask;
    logic [32:0] msb;
    r = {1'($urandom_range(0, 1)), $urandom()};
    mask = (et[2:1] == mna_pkg::ET_SIZE_8) ? 33'h0FF :
           (et[2:1] == mna_pkg::ET_SIZE_16) ? 33'h0FFFF : 33'h0FFFF_FFFF;
    msb = (mask >> 1) + 33'd1;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = '1;
      2: r = (r & ~mask) | msb;
      3: r = (r & ~mask) | (et[mna_pkg::ET_SIGNED_BIT] ? msb - 33'd1 : mask);
      4, 5: r = 33'($urandom_range(0, 15));
      default: ;
    endcase
    return r;
  endfunction

  // leaves tvalid high so back-to-back beats need no second assignment
  task automatic send_item(input logic [32:0] v, input logic is_last);
    int unsigned g;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, v};
    in_tlast <= is_last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic cfg_beat(input logic idx, input logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic wr_kind, input mna_pkg::norm_kind_t k,
                           input logic wr_type, input logic [2:0] et);
    // bit 2 of a kind write is don't-care
    if (wr_kind) cfg_beat(mna_pkg::REG_NORM_KIND, {1'($urandom_range(0, 1)), k});
    if (wr_type) begin
      cfg_beat(mna_pkg::REG_ELEM_TYPE, et);
      cur_type = et;
    end
    cfg_valid <= 1'b0;
  endtask

  // wait on the clock first so the checker's count includes the beat just taken
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned         base;
    int unsigned         len;
    int unsigned         nmat;
    int unsigned         wr;
    mna_pkg::norm_kind_t k;
    logic [2:0]          et;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(1'b1, mna_pkg::NK_MAX, 1'b1, ET_S8);
    send_item(33'h0_0000_0080, 1'b0);
    send_item(33'h0_0000_007F, 1'b1);
    settle();
    configure(1'b1, mna_pkg::NK_SUM, 1'b1, ET_S16);
    send_item(33'h0_0000_8000, 1'b0);
    send_item(33'h1_FFFF_FFFF, 1'b0);
    send_item(33'h0_0000_7FFF, 1'b1);
    settle();
    configure(1'b1, mna_pkg::NK_SQ, 1'b1, ET_S32);
    send_item(33'h1_8000_0000, 1'b0);
    send_item(33'h0_7FFF_FFFF, 1'b1);
    settle();
    configure(1'b1, mna_pkg::NK_ROOT, 1'b1, ET_U16);
    send_item(33'h0_0000_0000, 1'b1);
    send_item(33'h1_FFFF_FFFF, 1'b1);
    settle();
    // root of a clipped sum
    configure(1'b0, mna_pkg::NK_ROOT, 1'b1, ET_U32);
    send_item(33'h0_FFFF_FFFF, 1'b0);
    send_item(33'h0_FFFF_FFFF, 1'b1);
    settle();
    configure(1'b1, mna_pkg::NK_SUM, 1'b1, ET_U32_ALT);
    send_item(33'h1_FFFF_FFFF, 1'b1);
    settle();
    configure(1'b1, mna_pkg::NK_MAX, 1'b1, ET_S32_ALT);
    send_item(33'h1_FFFF_FFFF, 1'b0);
    send_item(33'h1_8000_0000, 1'b1);
    settle();
    configure(1'b1, mna_pkg::NK_SUM, 1'b1, ET_U8);
    send_item(33'h1_2345_67FF, 1'b1);
    settle();
    // clip under squares, then close the matrix under the max kind
    configure(1'b1, mna_pkg::NK_SQ, 1'b1, ET_U32);
    send_item(33'h0_FFFF_FFFF, 1'b0);
    send_item(33'h0_FFFF_FFFF, 1'b0);
    settle();
    configure(1'b1, mna_pkg::NK_MAX, 1'b0, ET_U32);
    send_item(33'h0_0000_0005, 1'b1);
    settle();
    configure(1'b1, mna_pkg::NK_SUM, 1'b0, ET_U32);
    send_item(33'h0_0000_0010, 1'b0);
    settle();
    configure(1'b1, mna_pkg::NK_ROOT, 1'b0, ET_U32);
    send_item(33'h0_0000_0003, 1'b1);
    settle();

    // fill the block while the result side is held off
    tx_gaps = 1'b0;
    configure(1'b1, mna_pkg::NK_ROOT, 1'b1, ET_S32);
    hold_requests++;
    repeat (30) send_item(pick_value(cur_type), 1'b1);
    settle();

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (items_sent - base > RANDOM_ITEMS - QUIET_TAIL) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else begin
        tx_gaps = $urandom_range(0, 9) < 7;
        rx_gaps = $urandom_range(0, 9) < 7;
      end
      k = mna_pkg::norm_kind_t'($urandom_range(0, 3));
      et = 3'($urandom_range(0, 7));
      wr = $urandom_range(0, 3);
      configure(wr != 1, k, wr != 2, et);
      nmat = $urandom_range(1, 6);
      repeat (nmat) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 1; i <= len; i++) send_item(pick_value(cur_type), i == len);
      end
      // sometimes carry an open matrix across the next setting
      if ($urandom_range(0, 4) == 0) send_item(pick_value(cur_type), 1'b0);
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mna_pkg.sv
hdl/mna_ctrl.sv
hdl/mna_dp.sv
hdl/matrix_norm_accumulator.sv
test/norm_result_checker.sv
test/tb.sv
